// File: sv/ahps_pkg.sv
`timescale 1ns / 1ps

package ahps_pkg;

    localparam int BYTE_W  = 8;
    localparam int TICKS_W = 16;
    localparam int CMD_W   = 2;
    localparam int ADDR_W  = 5;
    localparam int DATA_W  = 32;

    localparam logic [BYTE_W-1:0] RST_DELAY_COARSE = 8'd0;
    localparam logic [BYTE_W-1:0] RST_DELAY_FINE   = 8'd250;
    localparam logic [BYTE_W-1:0] RST_MAX_COARSE   = 8'd14;
    localparam logic [BYTE_W-1:0] RST_PWM_DUTY     = 8'd127;
    localparam logic [BYTE_W-1:0] RST_PWM_PERIOD   = 8'hff;

    typedef enum logic [CMD_W-1:0] {
        CMD_NOTE_ON  = 2'd0,
        CMD_NOTE_OFF = 2'd1,
        CMD_TICK     = 2'd2,
        CMD_NONE     = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_FIRST  = 2'd1,
        ST_SECOND = 2'd2
    } t_stage;

    typedef enum logic [2:0] {
        REG_DELAY_COARSE = 3'd0,
        REG_DELAY_FINE   = 3'd1,
        REG_MAX_COARSE   = 3'd2,
        REG_PWM_DUTY     = 3'd3,
        REG_PWM_PERIOD   = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [BYTE_W-1:0] delay_coarse;
        logic [BYTE_W-1:0] delay_fine;
        logic [BYTE_W-1:0] max_coarse;
        logic [BYTE_W-1:0] pwm_duty;
        logic [BYTE_W-1:0] pwm_period;
    } t_cfg;

    typedef struct packed {
        logic attack_level;
        logic hold_level;
        logic hold_active;
        logic sequencing;
        logic coarse_clamped;
    } t_result;

endpackage

// File: sv/ahps_in_if.sv
`timescale 1ns / 1ps

interface ahps_in_if;
    logic                          valid;
    logic                          ready;
    logic [ahps_pkg::CMD_W-1:0]    cmd;
    logic [ahps_pkg::BYTE_W-1:0]   attack_coarse;
    logic [ahps_pkg::BYTE_W-1:0]   attack_fine;
    logic                          timer_tick;
    logic                          pwm_tick;

    modport source (
        output valid, cmd, attack_coarse, attack_fine, timer_tick, pwm_tick,
        input  ready
    );
    modport sink (
        input  valid, cmd, attack_coarse, attack_fine, timer_tick, pwm_tick,
        output ready
    );
endinterface

// File: sv/ahps_out_if.sv
`timescale 1ns / 1ps

interface ahps_out_if;
    logic valid;
    logic ready;
    logic attack_level;
    logic hold_level;
    logic hold_active;
    logic sequencing;
    logic coarse_clamped;

    modport source (
        output valid, attack_level, hold_level, hold_active, sequencing, coarse_clamped,
        input  ready
    );
    modport sink (
        input  valid, attack_level, hold_level, hold_active, sequencing, coarse_clamped,
        output ready
    );
endinterface

// File: sv/ahps_cfg.sv
`timescale 1ns / 1ps

module ahps_cfg (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ahps_pkg::ADDR_W-1:0]  paddr,
    input  logic [ahps_pkg::DATA_W-1:0]  pwdata,
    output logic [ahps_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output ahps_pkg::t_cfg               o_cfg
);

    ahps_pkg::t_cfg   r_cfg;
    ahps_pkg::t_cfg   n_cfg;
    logic [2:0]       w_idx;
    logic             w_wr;
    logic [ahps_pkg::BYTE_W-1:0] w_rd;

    assign w_idx  = paddr[ahps_pkg::ADDR_W-1:2];
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;

    always_comb begin
        n_cfg = r_cfg;
        if (w_wr) begin
            case (ahps_pkg::t_reg_idx'(w_idx))
                ahps_pkg::REG_DELAY_COARSE: n_cfg.delay_coarse = pwdata[ahps_pkg::BYTE_W-1:0];
                ahps_pkg::REG_DELAY_FINE:   n_cfg.delay_fine   = pwdata[ahps_pkg::BYTE_W-1:0];
                ahps_pkg::REG_MAX_COARSE:   n_cfg.max_coarse   = pwdata[ahps_pkg::BYTE_W-1:0];
                ahps_pkg::REG_PWM_DUTY:     n_cfg.pwm_duty     = pwdata[ahps_pkg::BYTE_W-1:0];
                ahps_pkg::REG_PWM_PERIOD:   n_cfg.pwm_period   = pwdata[ahps_pkg::BYTE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ahps_pkg::t_reg_idx'(w_idx))
            ahps_pkg::REG_DELAY_COARSE: w_rd = r_cfg.delay_coarse;
            ahps_pkg::REG_DELAY_FINE:   w_rd = r_cfg.delay_fine;
            ahps_pkg::REG_MAX_COARSE:   w_rd = r_cfg.max_coarse;
            ahps_pkg::REG_PWM_DUTY:     w_rd = r_cfg.pwm_duty;
            ahps_pkg::REG_PWM_PERIOD:   w_rd = r_cfg.pwm_period;
            default:                    w_rd = '0;
        endcase
    end

    assign prdata = {{(ahps_pkg::DATA_W-ahps_pkg::BYTE_W){1'b0}}, w_rd};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.delay_coarse <= ahps_pkg::RST_DELAY_COARSE;
            r_cfg.delay_fine   <= ahps_pkg::RST_DELAY_FINE;
            r_cfg.max_coarse   <= ahps_pkg::RST_MAX_COARSE;
            r_cfg.pwm_duty     <= ahps_pkg::RST_PWM_DUTY;
            r_cfg.pwm_period   <= ahps_pkg::RST_PWM_PERIOD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: sv/ahps_core.sv
`timescale 1ns / 1ps

module ahps_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_accept,
    input  logic [ahps_pkg::CMD_W-1:0]  i_cmd,
    input  logic [ahps_pkg::BYTE_W-1:0] i_attack_coarse,
    input  logic [ahps_pkg::BYTE_W-1:0] i_attack_fine,
    input  logic                        i_timer_tick,
    input  logic                        i_pwm_tick,
    input  ahps_pkg::t_cfg              i_cfg,
    output ahps_pkg::t_result           o_result
);

    ahps_pkg::t_stage             r_stage,       n_stage;
    logic [ahps_pkg::TICKS_W-1:0] r_remaining,   n_remaining;
    logic [ahps_pkg::TICKS_W-1:0] r_second,      n_second;
    logic                         r_hold_first,  n_hold_first;
    logic                         r_attack,      n_attack;
    logic                         r_hold,        n_hold;
    logic                         r_pwm_on,      n_pwm_on;
    logic [ahps_pkg::BYTE_W-1:0]  r_pwm_count,   n_pwm_count;
    logic                         r_clamp,       n_clamp;

    logic                         w_over;
    logic [ahps_pkg::BYTE_W-1:0]  w_coarse;
    logic [ahps_pkg::TICKS_W-1:0] w_attk;
    logic [ahps_pkg::TICKS_W-1:0] w_dly;

    assign w_over   = i_attack_coarse > i_cfg.max_coarse;
    assign w_coarse = w_over ? i_cfg.max_coarse : i_attack_coarse;
    assign w_attk   = {w_coarse, i_attack_fine};
    assign w_dly    = {i_cfg.delay_coarse, i_cfg.delay_fine};

    always_comb begin
        n_stage      = r_stage;
        n_remaining  = r_remaining;
        n_second     = r_second;
        n_hold_first = r_hold_first;
        n_attack     = r_attack;
        n_hold       = r_hold;
        n_pwm_on     = r_pwm_on;
        n_pwm_count  = r_pwm_count;
        n_clamp      = r_clamp;
        case (ahps_pkg::t_cmd'(i_cmd))
            ahps_pkg::CMD_NOTE_ON: begin
                if (w_over) begin
                    n_clamp = 1'b1;
                end
                if (w_attk > w_dly) begin
                    n_remaining  = w_attk - w_dly;
                    n_second     = w_dly;
                    n_hold_first = 1'b1;
                end else begin
                    n_remaining  = w_attk;
                    n_second     = w_dly - w_attk;
                    n_hold_first = 1'b0;
                end
                n_stage  = ahps_pkg::ST_FIRST;
                n_hold   = 1'b0;
                n_attack = 1'b1;
            end
            ahps_pkg::CMD_NOTE_OFF: begin
                n_attack    = 1'b0;
                n_hold      = 1'b0;
                n_pwm_on    = 1'b0;
                n_stage     = ahps_pkg::ST_IDLE;
                n_remaining = '0;
            end
            ahps_pkg::CMD_TICK: begin
                // timer tick first, then the pwm tick sees its effect
                if (i_timer_tick && (r_stage == ahps_pkg::ST_FIRST ||
                                     r_stage == ahps_pkg::ST_SECOND)) begin
                    if (r_remaining > ahps_pkg::TICKS_W'(1)) begin
                        n_remaining = r_remaining - ahps_pkg::TICKS_W'(1);
                    end else if (r_stage == ahps_pkg::ST_FIRST) begin
                        n_stage     = ahps_pkg::ST_SECOND;
                        n_remaining = r_second;
                        if (r_hold_first) begin
                            n_pwm_on    = 1'b1;
                            n_pwm_count = i_cfg.pwm_period;
                        end else begin
                            n_attack = 1'b0;
                        end
                    end else begin
                        n_stage     = ahps_pkg::ST_IDLE;
                        n_remaining = '0;
                        if (r_hold_first) begin
                            n_attack = 1'b0;
                        end else begin
                            n_pwm_on    = 1'b1;
                            n_pwm_count = i_cfg.pwm_period;
                        end
                    end
                end
                if (i_pwm_tick && n_pwm_on) begin
                    if (n_pwm_count >= i_cfg.pwm_period) begin
                        n_pwm_count = '0;
                        n_hold      = 1'b1;
                    end else begin
                        n_pwm_count = n_pwm_count + ahps_pkg::BYTE_W'(1);
                    end
                    if (n_pwm_count == i_cfg.pwm_duty) begin
                        n_hold = 1'b0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        o_result.attack_level   = n_attack;
        o_result.hold_level     = n_hold;
        o_result.hold_active    = n_pwm_on;
        o_result.sequencing     = (n_stage == ahps_pkg::ST_FIRST) ||
                                  (n_stage == ahps_pkg::ST_SECOND);
        o_result.coarse_clamped = n_clamp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage      <= ahps_pkg::ST_IDLE;
            r_remaining  <= '0;
            r_second     <= '0;
            r_hold_first <= 1'b0;
            r_attack     <= 1'b0;
            r_hold       <= 1'b0;
            r_pwm_on     <= 1'b0;
            r_pwm_count  <= '0;
            r_clamp      <= 1'b0;
        end else if (i_accept) begin
            r_stage      <= n_stage;
            r_remaining  <= n_remaining;
            r_second     <= n_second;
            r_hold_first <= n_hold_first;
            r_attack     <= n_attack;
            r_hold       <= n_hold;
            r_pwm_on     <= n_pwm_on;
            r_pwm_count  <= n_pwm_count;
            r_clamp      <= n_clamp;
        end
    end

    // clamp error never clears once set
    a_clamp_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clamp |=> r_clamp)
        else $error("clamp flag dropped");

    a_note_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_cmd == ahps_pkg::CMD_NOTE_OFF) |=>
            (!r_attack && !r_hold && !r_pwm_on && r_stage == ahps_pkg::ST_IDLE))
        else $error("note off left outputs active");

    a_clamp_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_cmd == ahps_pkg::CMD_NOTE_ON &&
         i_attack_coarse > i_cfg.max_coarse) |=> r_clamp)
        else $error("oversized coarse value not flagged");

endmodule

// File: sv/ahps_obuf.sv
`timescale 1ns / 1ps

module ahps_obuf (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  ahps_pkg::t_result i_data,
    output logic              o_room,
    ahps_out_if.source        o_out
);

    logic              r_out_valid, n_out_valid;
    logic              r_skid_valid, n_skid_valid;
    ahps_pkg::t_result r_out_data, n_out_data;
    ahps_pkg::t_result r_skid_data, n_skid_data;
    logic              w_pop;

    assign o_room = !r_skid_valid;
    assign w_pop  = r_out_valid & o_out.ready;

    always_comb begin
        n_out_valid  = r_out_valid;
        n_skid_valid = r_skid_valid;
        n_out_data   = r_out_data;
        n_skid_data  = r_skid_data;
        if (w_pop) begin
            if (r_skid_valid) begin
                n_out_data   = r_skid_data;
                n_skid_valid = 1'b0;
            end else if (i_push) begin
                n_out_data = i_data;
            end else begin
                n_out_valid = 1'b0;
            end
        end else if (i_push) begin
            if (!r_out_valid) begin
                n_out_data  = i_data;
                n_out_valid = 1'b1;
            end else begin
                n_skid_data  = i_data;
                n_skid_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.attack_level   = r_out_data.attack_level;
    assign o_out.hold_level     = r_out_data.hold_level;
    assign o_out.hold_active    = r_out_data.hold_active;
    assign o_out.sequencing     = r_out_data.sequencing;
    assign o_out.coarse_clamped = r_out_data.coarse_clamped;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry without head entry");

endmodule

// File: sv/attack_hold_pulse_sequencer_unit.sv
`timescale 1ns / 1ps

// Solenoid note sequencer: takes one item per clock while ready is high (note on, note off,
// tick or none) and returns exactly one result item per input item, the pin levels and status
// after that item. The sequencing state is updated in a single pass at the accepting edge
// and the result is registered into the output buffer at that edge; a two-entry output buffer
// keeps input ready high while one result waits, and input stalls only when both entries are full.
// Registers on the APB port (delay_coarse, delay_fine, max_coarse, pwm_duty, pwm_period)
// are at byte addresses 0, 4, 8, 12 and 16 and take effect on the next item.
module attack_hold_pulse_sequencer_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ahps_pkg::ADDR_W-1:0]  paddr,
    input  logic [ahps_pkg::DATA_W-1:0]  pwdata,
    output logic [ahps_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    ahps_in_if.sink                      i_in,
    ahps_out_if.source                   o_out
);

    ahps_pkg::t_cfg    w_cfg;
    ahps_pkg::t_result w_result;
    logic              w_room;
    logic              w_accept;

    assign i_in.ready = w_room;
    assign w_accept   = i_in.valid & w_room;

    ahps_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    ahps_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_cmd           (i_in.cmd),
        .i_attack_coarse (i_in.attack_coarse),
        .i_attack_fine   (i_in.attack_fine),
        .i_timer_tick    (i_in.timer_tick),
        .i_pwm_tick      (i_in.pwm_tick),
        .i_cfg           (w_cfg),
        .o_result        (w_result)
    );

    ahps_obuf u_obuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_room  (w_room),
        .o_out   (o_out)
    );

endmodule
